### rtl/core/rv32im_execute_stage_macros.svh
// assertion helpers for the execute stage, clocked on clk, quiet during reset
`ifndef RV32IM_EXECUTE_STAGE_MACROS_SVH
`define RV32IM_EXECUTE_STAGE_MACROS_SVH

// same-cycle implication
`define RVEX_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define RVEX_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/core/rvex_pkg.sv
// ----------------------------------------------------------------------------
// rvex_pkg
// types, codes and constants shared by the execute stage modules
// ----------------------------------------------------------------------------
package rvex_pkg;

    localparam int XLEN      = 32;
    localparam int DIV_STEPS = XLEN;

    typedef logic [XLEN-1:0] word_t;

    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam word_t INSN_ECALL  = 32'h0000_0073;
    localparam word_t INSN_EBREAK = 32'h0010_0073;
    localparam word_t INSN_MRET   = 32'h3020_0073;

    typedef enum logic [3:0] {
        MEM_NONE = 4'd0,
        MEM_LB   = 4'd1,
        MEM_LBU  = 4'd2,
        MEM_LH   = 4'd3,
        MEM_LHU  = 4'd4,
        MEM_LW   = 4'd5,
        MEM_SB   = 4'd6,
        MEM_SH   = 4'd7,
        MEM_SW   = 4'd8
    } mem_kind_t;

    typedef enum logic [1:0] {
        TRAP_NONE    = 2'd0,
        TRAP_ECALL   = 2'd1,
        TRAP_EBREAK  = 2'd2,
        TRAP_ILLEGAL = 2'd3
    } trap_t;

    typedef enum logic [2:0] {
        MD_NONE   = 3'd0,
        MD_MUL_LO = 3'd1,
        MD_MUL_HI = 3'd2,
        MD_DIV    = 3'd3,
        MD_REM    = 3'd4
    } md_op_t;

    typedef struct packed {
        logic [4:0] rd_index;
        logic       rd_write;
        word_t      rd_value;
        word_t      next_pc;
        mem_kind_t  mem_kind;
        word_t      mem_address;
        word_t      store_data;
        logic       csr_write;
        word_t      csr_write_value;
        trap_t      trap_code;
    } res_t;

    typedef struct packed {
        md_op_t md;
        logic   neg_quo;
        logic   neg_rem;
        logic   div_zero;
        word_t  dividend;
    } div_ctl_t;

    typedef struct packed {
        res_t       res;
        div_ctl_t   ctl;
        logic [XLEN:0] mul_a;
        logic [XLEN:0] mul_b;
        word_t      div_a;
        word_t      div_b;
    } dec_t;

    typedef struct packed {
        res_t     res;
        div_ctl_t ctl;
        word_t    rem;
        word_t    quo;
        word_t    dsr;
    } div_stage_t;

endpackage

### rtl/core/rvex_channels.sv
// ----------------------------------------------------------------------------
// rvex_channels
// valid/ready channels for instructions in and results out
// ----------------------------------------------------------------------------
interface rvex_issue_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    logic [31:0] pc;
    logic [31:0] rs1_value;
    logic [31:0] rs2_value;
    logic [31:0] csr_read_value;
    logic [31:0] trap_vector;
    logic [31:0] return_pc;

    modport source (
        output valid, instruction, pc, rs1_value, rs2_value, csr_read_value,
               trap_vector, return_pc,
        input  ready
    );
    modport sink (
        input  valid, instruction, pc, rs1_value, rs2_value, csr_read_value,
               trap_vector, return_pc,
        output ready
    );
endinterface

interface rvex_result_if;
    logic        valid;
    logic        ready;
    logic [4:0]  rd_index;
    logic        rd_write;
    logic [31:0] rd_value;
    logic [31:0] next_pc;
    logic [3:0]  mem_kind;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic        csr_write;
    logic [31:0] csr_write_value;
    logic [1:0]  trap_code;

    modport source (
        output valid, rd_index, rd_write, rd_value, next_pc, mem_kind, mem_address,
               store_data, csr_write, csr_write_value, trap_code,
        input  ready
    );
    modport sink (
        input  valid, rd_index, rd_write, rd_value, next_pc, mem_kind, mem_address,
               store_data, csr_write, csr_write_value, trap_code,
        output ready
    );
endinterface

### rtl/core/rvex_decode.sv
// ----------------------------------------------------------------------------
// rvex_decode
// instruction decode, integer alu, branch, memory and csr results
// ----------------------------------------------------------------------------
module rvex_decode
    import rvex_pkg::*;
(
    input  word_t instruction,
    input  word_t pc,
    input  word_t rs1_value,
    input  word_t rs2_value,
    input  word_t csr_read_value,
    input  word_t trap_vector,
    input  word_t return_pc,
    output dec_t  dec
);

    function automatic word_t alu(input logic [2:0] f3, input word_t a, input word_t b,
                                  input logic alt);
        word_t r;
        case (f3)
            3'd0:    r = alt ? a - b : a + b;
            3'd1:    r = a << b[4:0];
            3'd2:    r = ($signed(a) < $signed(b)) ? word_t'(1) : word_t'(0);
            3'd3:    r = (a < b) ? word_t'(1) : word_t'(0);
            3'd4:    r = a ^ b;
            3'd5:    r = alt ? word_t'($signed(a) >>> b[4:0]) : a >> b[4:0];
            3'd6:    r = a | b;
            default: r = a & b;
        endcase
        return r;
    endfunction

    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [4:0] rd;
    logic [4:0] rs1f;
    word_t      imm_i;
    word_t      imm_s;
    word_t      imm_b;
    word_t      imm_j;
    word_t      imm_u;
    word_t      pc_plus4;
    word_t      csr_src;
    logic       wr;
    logic       ill;
    logic       take;
    logic       sgn;
    res_t       r;
    md_op_t     md;

    assign op    = instruction[6:0];
    assign f3    = instruction[14:12];
    assign f7    = instruction[31:25];
    assign rd    = instruction[11:7];
    assign rs1f  = instruction[19:15];
    assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
    assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                    instruction[30:25], instruction[11:8], 1'b0};
    assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                    instruction[20], instruction[30:21], 1'b0};
    assign imm_u = {instruction[31:12], 12'b0};
    assign pc_plus4 = pc + word_t'(4);
    assign csr_src  = f3[2] ? {27'b0, rs1f} : rs1_value;

    always_comb
    begin
        wr   = 1'b0;
        ill  = 1'b0;
        take = 1'b0;
        md   = MD_NONE;
        r    = '0;
        r.rd_index  = rd;
        r.next_pc   = pc_plus4;
        r.mem_kind  = MEM_NONE;
        r.trap_code = TRAP_NONE;
        case (op)
            OP_REG:
            begin
                wr = 1'b1;
                if (f7 == F7_BASE)
                    r.rd_value = alu(f3, rs1_value, rs2_value, 1'b0);
                else if (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))
                    r.rd_value = alu(f3, rs1_value, rs2_value, 1'b1);
                else if (f7 == F7_MULDIV)
                begin
                    case (f3)
                        3'd0:            md = MD_MUL_LO;
                        3'd1, 3'd2, 3'd3: md = MD_MUL_HI;
                        3'd4, 3'd5:      md = MD_DIV;
                        default:         md = MD_REM;
                    endcase
                end
                else
                    ill = 1'b1;
            end
            OP_IMM:
            begin
                wr = 1'b1;
                if (f3 == 3'd1 && f7 != F7_BASE)
                    ill = 1'b1;
                else if (f3 == 3'd5 && f7 != F7_BASE && f7 != F7_ALT)
                    ill = 1'b1;
                else
                    r.rd_value = alu(f3, rs1_value, imm_i, f3 == 3'd5 && f7 == F7_ALT);
            end
            OP_LOAD:
            begin
                case (f3)
                    3'd0:    r.mem_kind = MEM_LB;
                    3'd4:    r.mem_kind = MEM_LBU;
                    3'd1:    r.mem_kind = MEM_LH;
                    3'd5:    r.mem_kind = MEM_LHU;
                    3'd2:    r.mem_kind = MEM_LW;
                    default: ill = 1'b1;
                endcase
                wr = 1'b1;
                r.mem_address = rs1_value + imm_i;
            end
            OP_STORE:
            begin
                case (f3)
                    3'd0:    r.mem_kind = MEM_SB;
                    3'd1:    r.mem_kind = MEM_SH;
                    3'd2:    r.mem_kind = MEM_SW;
                    default: ill = 1'b1;
                endcase
                r.mem_address = rs1_value + imm_s;
                r.store_data  = rs2_value;
            end
            OP_BRANCH:
            begin
                case (f3)
                    3'd0:    take = (rs1_value == rs2_value);
                    3'd1:    take = (rs1_value != rs2_value);
                    3'd4:    take = ($signed(rs1_value) < $signed(rs2_value));
                    3'd5:    take = !($signed(rs1_value) < $signed(rs2_value));
                    3'd6:    take = (rs1_value < rs2_value);
                    3'd7:    take = (rs1_value >= rs2_value);
                    default: ill = 1'b1;
                endcase
                if (take)
                    r.next_pc = pc + imm_b;
            end
            OP_LUI:
            begin
                wr = 1'b1;
                r.rd_value = imm_u;
            end
            OP_AUIPC:
            begin
                wr = 1'b1;
                r.rd_value = pc + imm_u;
            end
            OP_JAL:
            begin
                wr = 1'b1;
                r.rd_value = pc_plus4;
                r.next_pc  = pc + imm_j;
            end
            OP_JALR:
            begin
                if (f3 == 3'd0)
                begin
                    wr = 1'b1;
                    r.rd_value = pc_plus4;
                    r.next_pc  = (rs1_value + imm_i) & ~word_t'(1);
                end
                else
                    ill = 1'b1;
            end
            OP_SYSTEM:
            begin
                if (f3 == 3'd0)
                begin
                    if (instruction == INSN_ECALL)
                    begin
                        r.trap_code = TRAP_ECALL;
                        r.next_pc   = trap_vector;
                    end
                    else if (instruction == INSN_EBREAK)
                        r.trap_code = TRAP_EBREAK;
                    else if (instruction == INSN_MRET)
                        r.next_pc = return_pc;
                    else
                        ill = 1'b1;
                end
                else if (f3 == 3'd4)
                    ill = 1'b1;
                else
                begin
                    wr = 1'b1;
                    r.rd_value = csr_read_value;
                    case (f3[1:0])
                        2'd1:
                        begin
                            r.csr_write_value = csr_src;
                            r.csr_write       = 1'b1;
                        end
                        2'd2:
                        begin
                            r.csr_write_value = csr_read_value | csr_src;
                            r.csr_write       = (rs1f != 5'd0);
                        end
                        default:
                        begin
                            r.csr_write_value = csr_read_value & ~csr_src;
                            r.csr_write       = (rs1f != 5'd0);
                        end
                    endcase
                end
            end
            default: ill = 1'b1;
        endcase

        if (ill)
        begin
            r = '0;
            r.rd_index  = rd;
            r.next_pc   = pc_plus4;
            r.mem_kind  = MEM_NONE;
            r.trap_code = TRAP_ILLEGAL;
            wr = 1'b0;
            md = MD_NONE;
        end
        if (rd == 5'd0)
            wr = 1'b0;
        if (!wr || op == OP_LOAD)
            r.rd_value = '0;
        r.rd_write = wr;
    end

    assign sgn = (f3 == 3'd4 || f3 == 3'd6);

    always_comb
    begin
        dec          = '0;
        dec.res      = r;
        dec.ctl.md   = md;
        dec.mul_a    = {(f3 == 3'd1 || f3 == 3'd2) && rs1_value[31], rs1_value};
        dec.mul_b    = {(f3 == 3'd1) && rs2_value[31], rs2_value};
        dec.div_a    = (sgn && rs1_value[31]) ? word_t'(0) - rs1_value : rs1_value;
        dec.div_b    = (sgn && rs2_value[31]) ? word_t'(0) - rs2_value : rs2_value;
        dec.ctl.neg_quo  = sgn && (rs1_value[31] ^ rs2_value[31]);
        dec.ctl.neg_rem  = sgn && rs1_value[31];
        dec.ctl.div_zero = (rs2_value == '0);
        dec.ctl.dividend = rs1_value;
    end

endmodule

### rtl/core/rvex_divider.sv
// ----------------------------------------------------------------------------
// rvex_divider
// restoring divider, one quotient bit per pipeline stage, payload rides along
// ----------------------------------------------------------------------------
module rvex_divider
    import rvex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       in_vld,
    input  res_t       in_res,
    input  div_ctl_t   in_ctl,
    input  word_t      in_dividend,
    input  word_t      in_divisor,
    output logic       out_vld,
    output div_stage_t out_stage
);

    div_stage_t             cur     [0:DIV_STEPS-1];
    div_stage_t             stg_reg [1:DIV_STEPS];
    logic [DIV_STEPS:1]     vld_reg;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        logic [XLEN:0] trial;
        logic [XLEN:0] diff;
        div_stage_t    stg_next;
        logic          vld_in;

        if (i > 0)
        begin : g_tap
            assign cur[i] = stg_reg[i];
            assign vld_in = vld_reg[i];
        end
        else
        begin : g_head
            assign cur[i] = {in_res, in_ctl, word_t'(0), in_dividend, in_divisor};
            assign vld_in = in_vld;
        end

        always_comb
        begin
            trial    = {cur[i].rem, cur[i].quo[XLEN-1]};
            diff     = trial - {1'b0, cur[i].dsr};
            stg_next = cur[i];
            stg_next.rem = diff[XLEN] ? trial[XLEN-1:0] : diff[XLEN-1:0];
            stg_next.quo = {cur[i].quo[XLEN-2:0], !diff[XLEN]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (adv)
                vld_reg[i+1] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                stg_reg[i+1] <= stg_next;
        end
    end

    assign out_vld   = vld_reg[DIV_STEPS];
    assign out_stage = stg_reg[DIV_STEPS];

endmodule

### rtl/core/rv32im_execute_stage.sv
// ----------------------------------------------------------------------------
// rv32im_execute_stage
// rv32im + zicsr execute unit, fully pipelined
// ----------------------------------------------------------------------------
// issue carries one instruction with its pc, both source values, the csr
// value, mtvec and mepc; result carries rd, next pc, the memory request, the
// csr write and the trap code. both channels are valid/ready.
// 35 register stages: decode, multiply, 32 divider stages (one
// quotient bit each) and the output register.
// every instruction runs the full depth so results leave in issue order.
// throughput: one item per cycle; issue.ready is high whenever the output
// register is empty or being taken.
// when result.ready is low with a result waiting, the whole pipeline holds
// and issue.ready drops; nothing is lost or repeated.
// reset clears all valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
`include "rv32im_execute_stage_macros.svh"

module rv32im_execute_stage
    import rvex_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rvex_issue_if.sink   issue,
    rvex_result_if.source result
);

    logic       adv;
    dec_t       dec;
    logic       s1_vld_reg;
    dec_t       s1_reg;
    logic       s2_vld_reg;
    dec_t       s2_reg;
    logic [2*XLEN-1:0] prod_reg;
    logic [2*XLEN+1:0] prod_full;
    res_t       div_in_res;
    logic       div_vld;
    div_stage_t div_out;
    res_t       out_next;
    logic       out_vld_reg;
    res_t       out_reg;

    assign adv         = !out_vld_reg || result.ready;
    assign issue.ready = adv;

    rvex_decode u_decode (
        .instruction    (issue.instruction),
        .pc             (issue.pc),
        .rs1_value      (issue.rs1_value),
        .rs2_value      (issue.rs2_value),
        .csr_read_value (issue.csr_read_value),
        .trap_vector    (issue.trap_vector),
        .return_pc      (issue.return_pc),
        .dec            (dec)
    );

    assign prod_full = $signed(s1_reg.mul_a) * $signed(s1_reg.mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= issue.valid;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= dec;
            s2_reg   <= s1_reg;
            prod_reg <= prod_full[2*XLEN-1:0];
            out_reg  <= out_next;
        end
    end

    always_comb
    begin
        div_in_res = s2_reg.res;
        if (s2_reg.res.rd_write && s2_reg.ctl.md == MD_MUL_LO)
            div_in_res.rd_value = prod_reg[XLEN-1:0];
        else if (s2_reg.res.rd_write && s2_reg.ctl.md == MD_MUL_HI)
            div_in_res.rd_value = prod_reg[2*XLEN-1:XLEN];
    end

    rvex_divider u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_vld      (s2_vld_reg),
        .in_res      (div_in_res),
        .in_ctl      (s2_reg.ctl),
        .in_dividend (s2_reg.div_a),
        .in_divisor  (s2_reg.div_b),
        .out_vld     (div_vld),
        .out_stage   (div_out)
    );

    always_comb
    begin
        out_next = div_out.res;
        if (div_out.res.rd_write && div_out.ctl.md == MD_DIV)
        begin
            if (div_out.ctl.div_zero)
                out_next.rd_value = '1;
            else if (div_out.ctl.neg_quo)
                out_next.rd_value = word_t'(0) - div_out.quo;
            else
                out_next.rd_value = div_out.quo;
        end
        else if (div_out.res.rd_write && div_out.ctl.md == MD_REM)
        begin
            if (div_out.ctl.div_zero)
                out_next.rd_value = div_out.ctl.dividend;
            else if (div_out.ctl.neg_rem)
                out_next.rd_value = word_t'(0) - div_out.rem;
            else
                out_next.rd_value = div_out.rem;
        end
    end

    assign result.valid           = out_vld_reg;
    assign result.rd_index        = out_reg.rd_index;
    assign result.rd_write        = out_reg.rd_write;
    assign result.rd_value        = out_reg.rd_value;
    assign result.next_pc         = out_reg.next_pc;
    assign result.mem_kind        = out_reg.mem_kind;
    assign result.mem_address     = out_reg.mem_address;
    assign result.store_data      = out_reg.store_data;
    assign result.csr_write       = out_reg.csr_write;
    assign result.csr_write_value = out_reg.csr_write_value;
    assign result.trap_code       = out_reg.trap_code;

    `RVEX_ASSERT_NOW(a_illegal_clean, out_vld_reg && out_reg.trap_code == TRAP_ILLEGAL, !out_reg.rd_write && out_reg.mem_kind == MEM_NONE && !out_reg.csr_write, "illegal item has side effects")
    `RVEX_ASSERT_NOW(a_x0_no_write, out_vld_reg && out_reg.rd_index == 5'd0, !out_reg.rd_write, "write to x0")
    `RVEX_ASSERT_NEXT(a_stall_holds, !adv, $stable(div_vld) && $stable(s2_vld_reg) && $stable(out_vld_reg), "pipeline moved during stall")

endmodule

### bench/rv32im_execute_stage_tb.sv
// ----------------------------------------------------------------------------
// rv32im_execute_stage_tb
// self-checking bench for the rv32im + zicsr execute stage: directed corner
// instructions, then random well-formed and random raw words, with random
// gaps on both channels; every result is checked field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32im_execute_stage_tb;
    import rvex_pkg::*;

    typedef struct {
        logic [31:0] insn;
        logic [31:0] pc;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] csrv;
        logic [31:0] tvec;
        logic [31:0] epc;
    } insn_item_t;

    // signed compare without relying on signed types
    function automatic bit lt_s(logic [31:0] x, logic [31:0] y);
        return (x ^ 32'h8000_0000) < (y ^ 32'h8000_0000);
    endfunction

    function automatic logic [31:0] muldiv(logic [2:0] f3, logic [31:0] x, logic [31:0] y);
        logic [63:0] p;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] q;
        bit ovf;
        ovf = (x == 32'h8000_0000) && (y == 32'hFFFF_FFFF);
        mx = x[31] ? -x : x;
        my = y[31] ? -y : y;
        case (f3)
            3'd0: return x * y;
            3'd1:
            begin
                p = {{32{x[31]}}, x} * {{32{y[31]}}, y};
                return p[63:32];
            end
            3'd2:
            begin
                p = {{32{x[31]}}, x} * {32'd0, y};
                return p[63:32];
            end
            3'd3:
            begin
                p = {32'd0, x} * {32'd0, y};
                return p[63:32];
            end
            3'd4:
            begin
                if (y == 0) return 32'hFFFF_FFFF;
                if (ovf) return x;
                q = mx / my;
                return (x[31] ^ y[31]) ? -q : q;
            end
            3'd5: return (y == 0) ? 32'hFFFF_FFFF : x / y;
            3'd6:
            begin
                if (y == 0) return x;
                if (ovf) return 32'd0;
                q = mx % my;
                return x[31] ? -q : q;
            end
            default: return (y == 0) ? x : x % y;
        endcase
    endfunction

    function automatic res_t execute(insn_item_t it);
        res_t r;
        logic [31:0] ins;
        logic [6:0] op;
        logic [6:0] f7;
        logic [2:0] f3;
        logic [4:0] rs1f;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        logic [31:0] src;
        logic [4:0] sh;
        bit wr;
        bit ill;
        bit take;
        ins = it.insn;
        op = ins[6:0];
        f3 = ins[14:12];
        f7 = ins[31:25];
        rs1f = ins[19:15];
        sh = ins[24:20];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        r = '0;
        r.rd_index = ins[11:7];
        r.next_pc = it.pc + 4;
        r.mem_kind = MEM_NONE;
        r.trap_code = TRAP_NONE;
        wr = 0;
        ill = 0;
        take = 0;
        case (op)
            OP_REG:
            begin
                wr = 1;
                if (f7 == F7_BASE)
                    case (f3)
                        3'd0: r.rd_value = it.a + it.b;
                        3'd1: r.rd_value = it.a << it.b[4:0];
                        3'd2: r.rd_value = {31'd0, lt_s(it.a, it.b)};
                        3'd3: r.rd_value = {31'd0, it.a < it.b};
                        3'd4: r.rd_value = it.a ^ it.b;
                        3'd5: r.rd_value = it.a >> it.b[4:0];
                        3'd6: r.rd_value = it.a | it.b;
                        default: r.rd_value = it.a & it.b;
                    endcase
                else if (f7 == F7_ALT && f3 == 3'd0) r.rd_value = it.a - it.b;
                else if (f7 == F7_ALT && f3 == 3'd5)
                    r.rd_value = $unsigned($signed(it.a) >>> it.b[4:0]);
                else if (f7 == F7_MULDIV) r.rd_value = muldiv(f3, it.a, it.b);
                else ill = 1;
            end
            OP_IMM:
            begin
                wr = 1;
                case (f3)
                    3'd0: r.rd_value = it.a + imm_i;
                    3'd1: if (f7 == F7_BASE) r.rd_value = it.a << sh; else ill = 1;
                    3'd2: r.rd_value = {31'd0, lt_s(it.a, imm_i)};
                    3'd3: r.rd_value = {31'd0, it.a < imm_i};
                    3'd4: r.rd_value = it.a ^ imm_i;
                    3'd5:
                        if (f7 == F7_BASE) r.rd_value = it.a >> sh;
                        else if (f7 == F7_ALT) r.rd_value = $unsigned($signed(it.a) >>> sh);
                        else ill = 1;
                    3'd6: r.rd_value = it.a | imm_i;
                    default: r.rd_value = it.a & imm_i;
                endcase
            end
            OP_LOAD:
            begin
                case (f3)
                    3'd0: r.mem_kind = MEM_LB;
                    3'd4: r.mem_kind = MEM_LBU;
                    3'd1: r.mem_kind = MEM_LH;
                    3'd5: r.mem_kind = MEM_LHU;
                    3'd2: r.mem_kind = MEM_LW;
                    default: ill = 1;
                endcase
                if (!ill)
                begin
                    wr = 1;
                    r.mem_address = it.a + imm_i;
                end
            end
            OP_STORE:
            begin
                case (f3)
                    3'd0: r.mem_kind = MEM_SB;
                    3'd1: r.mem_kind = MEM_SH;
                    3'd2: r.mem_kind = MEM_SW;
                    default: ill = 1;
                endcase
                if (!ill)
                begin
                    r.mem_address = it.a + imm_s;
                    r.store_data = it.b;
                end
            end
            OP_BRANCH:
            begin
                case (f3)
                    3'd0: take = it.a == it.b;
                    3'd1: take = it.a != it.b;
                    3'd4: take = lt_s(it.a, it.b);
                    3'd5: take = !lt_s(it.a, it.b);
                    3'd6: take = it.a < it.b;
                    3'd7: take = it.a >= it.b;
                    default: ill = 1;
                endcase
                if (take) r.next_pc = it.pc + imm_b;
            end
            OP_LUI:
            begin
                wr = 1;
                r.rd_value = {ins[31:12], 12'd0};
            end
            OP_AUIPC:
            begin
                wr = 1;
                r.rd_value = it.pc + {ins[31:12], 12'd0};
            end
            OP_JAL:
            begin
                wr = 1;
                r.rd_value = it.pc + 4;
                r.next_pc = it.pc + imm_j;
            end
            OP_JALR:
                if (f3 == 3'd0)
                begin
                    wr = 1;
                    r.rd_value = it.pc + 4;
                    r.next_pc = (it.a + imm_i) & ~32'd1;
                end
                else ill = 1;
            OP_SYSTEM:
                if (f3 == 3'd0)
                begin
                    if (ins == INSN_ECALL)
                    begin
                        r.trap_code = TRAP_ECALL;
                        r.next_pc = it.tvec;
                    end
                    else if (ins == INSN_EBREAK) r.trap_code = TRAP_EBREAK;
                    else if (ins == INSN_MRET) r.next_pc = it.epc;
                    else ill = 1;
                end
                else if (f3 == 3'd4) ill = 1;
                else
                begin
                    src = f3[2] ? {27'd0, rs1f} : it.a;
                    wr = 1;
                    r.rd_value = it.csrv;
                    case (f3[1:0])
                        2'd1:
                        begin
                            r.csr_write_value = src;
                            r.csr_write = 1;
                        end
                        2'd2:
                        begin
                            r.csr_write_value = it.csrv | src;
                            r.csr_write = rs1f != 0;
                        end
                        default:
                        begin
                            r.csr_write_value = it.csrv & ~src;
                            r.csr_write = rs1f != 0;
                        end
                    endcase
                end
            default: ill = 1;
        endcase
        if (ill)
        begin
            r = '0;
            r.rd_index = ins[11:7];
            r.next_pc = it.pc + 4;
            r.mem_kind = MEM_NONE;
            r.trap_code = TRAP_ILLEGAL;
            wr = 0;
        end
        if (r.rd_index == 0) wr = 0;
        if (!wr || op == OP_LOAD) r.rd_value = '0;
        r.rd_write = wr;
        return r;
    endfunction

    class exec_scoreboard;
        res_t pending[$];
        int mismatches;
        int checked;

        function void note_issue(insn_item_t it);
            pending.push_back(execute(it));
        endfunction

        function void check_result(res_t got);
            res_t exp;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: %p", got);
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch on result %0d", checked);
                    $display("  expected %p", exp);
                    $display("  actual   %p", got);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    rvex_issue_if issue ();
    rvex_result_if result ();
    exec_scoreboard board;
    int cycles;
    int sent;

    rv32im_execute_stage u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue.sink),
        .result (result.source)
    );

    initial clk = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: sample at the edge, random stalls
    initial
    begin
        int gap;
        result.ready = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (gap != 0)
            begin
                result.ready <= 0;
                repeat (gap) @(posedge clk);
            end
            result.ready <= 1;
            @(posedge clk iff result.valid);
            board.check_result({result.rd_index, result.rd_write, result.rd_value,
                                result.next_pc, mem_kind_t'(result.mem_kind),
                                result.mem_address, result.store_data, result.csr_write,
                                result.csr_write_value, trap_t'(result.trap_code)});
        end
    end

    task automatic send(insn_item_t it, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            issue.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        issue.valid <= 1;
        issue.instruction <= it.insn;
        issue.pc <= it.pc;
        issue.rs1_value <= it.a;
        issue.rs2_value <= it.b;
        issue.csr_read_value <= it.csrv;
        issue.trap_vector <= it.tvec;
        issue.return_pc <= it.epc;
        @(posedge clk iff issue.ready);
        board.note_issue(it);
        sent++;
    endtask

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic insn_item_t rand_operands(logic [31:0] insn);
        insn_item_t it;
        it.insn = insn;
        it.pc = $urandom;
        it.a = edge_word();
        it.b = ($urandom_range(0, 5) == 0) ? it.a : edge_word();
        it.csrv = $urandom;
        it.tvec = $urandom;
        it.epc = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] rand_insn();
        logic [31:0] w;
        logic [6:0] ops[10];
        logic [2:0] f3;
        ops = '{OP_LOAD, OP_IMM, OP_AUIPC, OP_STORE, OP_REG, OP_LUI, OP_BRANCH,
                OP_JALR, OP_JAL, OP_SYSTEM};
        w = $urandom;
        if ($urandom_range(0, 9) == 0) return w;
        w[6:0] = ops[$urandom_range(0, 9)];
        f3 = w[14:12];
        case (w[6:0])
            OP_REG:
                case ($urandom_range(0, 3))
                    0: w[31:25] = F7_BASE;
                    1: w[31:25] = F7_MULDIV;
                    2: w[31:25] = F7_ALT;
                    default: ;
                endcase
            OP_IMM:
                if ((f3 == 3'd1 || f3 == 3'd5) && $urandom_range(0, 3) != 0)
                    w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
            OP_LOAD: if ($urandom_range(0, 7) != 0) w[14:12] = 3'($urandom_range(0, 5));
            OP_STORE: if ($urandom_range(0, 7) != 0) w[14:12] = 3'($urandom_range(0, 2));
            OP_JALR: if ($urandom_range(0, 7) != 0) w[14:12] = 3'd0;
            OP_SYSTEM:
                case ($urandom_range(0, 5))
                    0: w = INSN_ECALL;
                    1: w = INSN_EBREAK;
                    2: w = INSN_MRET;
                    3: if ($urandom_range(0, 1)) w[19:15] = 5'd0;
                    default: ;
                endcase
            default: ;
        endcase
        if ($urandom_range(0, 15) == 0 && w[6:0] != OP_SYSTEM) w[11:7] = 5'd0;
        return w;
    endfunction

    initial
    begin
        insn_item_t it;
        logic [31:0] directed[$];
        int idx;
        board = new();
        cycles = 0;
        sent = 0;
        rst_n = 0;
        issue.valid = 0;
        issue.instruction = '0;
        issue.pc = '0;
        issue.rs1_value = '0;
        issue.rs2_value = '0;
        issue.csr_read_value = '0;
        issue.trap_vector = '0;
        issue.return_pc = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // div/rem by zero, all mul/div ops, loads, stores,
        // csr set/clear with zero source, system words, illegal cases
        directed = '{32'h0220_C0B3, 32'h0220_D0B3, 32'h0220_E0B3, 32'h0220_F0B3,
                     32'h0220_80B3, 32'h0220_90B3, 32'h0220_A0B3, 32'h0220_B0B3,
                     32'h4020_00B3, 32'h4020_50B3, 32'h0000_0083, 32'hFFF0_C083,
                     32'h0020_A023, 32'hFE00_9FA3, 32'h0000_2073, 32'h0000_3073,
                     32'h0000_6073, 32'h0000_7073, 32'hFFF0_0067, INSN_ECALL,
                     INSN_EBREAK, INSN_MRET, 32'h0000_000F, 32'h4000_1013,
                     32'hFFFF_F0EF};
        for (idx = 0; idx < directed.size(); idx++)
        begin
            it = rand_operands(directed[idx]);
            if (idx < 8)
            begin
                it.a = (idx % 2) ? 32'h8000_0000 : $urandom;
                it.b = (idx % 2) ? 32'hFFFF_FFFF : 32'd0;
            end
            send(it, 0);
        end

        for (idx = 0; idx < 1300; idx++)
        begin
            if (idx == 600)
            begin
                issue.valid <= 0;
                @(posedge clk iff board.pending.size() == 0);
            end
            send(rand_operands(rand_insn()), (idx / 100) % 3 == 1);
        end
        issue.valid <= 0;

        @(posedge clk iff board.pending.size() == 0);
        repeat (50) @(posedge clk);
        $display("%0d instructions issued, %0d results checked, %0d mismatches",
                 sent, board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
